// ===== hdl/elapsed_time_matrix_renderer_core_assert.svh =====
// Assertion macros shared by the elapsed-time matrix renderer RTL.
`ifndef ELAPSED_TIME_MATRIX_RENDERER_CORE_ASSERT_SVH
`define ELAPSED_TIME_MATRIX_RENDERER_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define ETMR_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("etmr: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define ETMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("etmr: next-cycle check failed");

`endif

// ===== hdl/etmr_pkg.sv =====
// Shared types, constants and font table for the elapsed-time matrix renderer.
`timescale 1ns / 1ps

package etmr_pkg;

    // Field widths.
    localparam int TIME_W = 16;
    localparam int MODE_W = 2;
    localparam int SEC_W  = 20;
    localparam int ROW_W  = 3;
    localparam int PIX_W  = 32;

    // Frame buffer: two banks of eight rows.
    localparam int FRAME_ROWS = 8;
    localparam int RAM_DEPTH  = 2 * FRAME_ROWS;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);

    // Time arithmetic.
    localparam logic [TIME_W-1:0] TIME_LIMIT = 16'd35999;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int MAX_HOURS     = 9;
    localparam logic [16:0] MIN_RECIP = 17'd34953;
    localparam int MIN_SHIFT = 21;

    // Progress bar: 63 * elapsed needs 26 bits.
    localparam int BAR_W = SEC_W + 6;

    // Play mode codes.
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd3;

    // Glyph codes beyond the ten digits.
    localparam logic [3:0] GLYPH_COLON = 4'd10;
    localparam logic [3:0] GLYPH_PLAY  = 4'd11;
    localparam logic [3:0] GLYPH_PAUSE = 4'd12;
    localparam logic [3:0] GLYPH_STOP  = 4'd13;

    // Special rows.
    localparam logic [ROW_W-1:0] BLANK_ROW    = 3'd5;
    localparam logic [ROW_W-1:0] BAR_ROW_ODD  = 3'd6;
    localparam logic [ROW_W-1:0] LAST_ROW     = 3'd7;

    // Cell origins (left column of each 8-wide cell).
    localparam logic [4:0] X_ICON      = 5'd0;
    localparam logic [4:0] X_HOURS     = 5'd7;
    localparam logic [4:0] X_COLON_H   = 5'd11;
    localparam logic [4:0] X_MIN_TENS  = 5'd13;
    localparam logic [4:0] X_MIN_UNITS = 5'd17;
    localparam logic [4:0] X_COLON_M   = 5'd21;
    localparam logic [4:0] X_SEC_TENS  = 5'd23;
    localparam logic [4:0] X_SEC_UNITS = 5'd27;

    // Everything the row drawer needs to know about one frame.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hour_mode;
        logic [3:0]        hours;
        logic [3:0]        min_tens;
        logic [3:0]        min_units;
        logic [3:0]        sec_tens;
        logic [3:0]        sec_units;
        logic              bar_dark;
        logic [5:0]        bar_level;
    } frame_params_t;

    // 3x5 font: five row bytes, top row in the upper byte.
    function automatic logic [39:0] font_glyph(input logic [3:0] glyph);
        logic [39:0] v;
        case (glyph)
            4'd0:        v = 40'h2050505020;
            4'd1:        v = 40'h2060202070;
            4'd2:        v = 40'h6010204070;
            4'd3:        v = 40'h6010601060;
            4'd4:        v = 40'h5050701010;
            4'd5:        v = 40'h7040601060;
            4'd6:        v = 40'h2040605020;
            4'd7:        v = 40'h7010202020;
            4'd8:        v = 40'h2050205020;
            4'd9:        v = 40'h2050301020;
            GLYPH_COLON: v = 40'h0040004000;
            GLYPH_PLAY:  v = 40'h4060706040;
            GLYPH_PAUSE: v = 40'h5050505050;
            GLYPH_STOP:  v = 40'h0070707000;
            default:     v = 40'h0;
        endcase
        return v;
    endfunction

    // One row byte of a glyph; rows below the glyph are dark.
    function automatic logic [7:0] glyph_row(input logic [3:0] glyph,
                                             input logic [ROW_W-1:0] row);
        logic [39:0] v;
        logic [7:0]  b;
        v = font_glyph(glyph);
        case (row)
            3'd0:    b = v[39:32];
            3'd1:    b = v[31:24];
            3'd2:    b = v[23:16];
            3'd3:    b = v[15:8];
            3'd4:    b = v[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/elapsed_time_matrix_renderer_core.sv =====
// Elapsed-time matrix renderer: top level with row drawer, frame buffer and row reader.
`timescale 1ns / 1ps
`include "elapsed_time_matrix_renderer_core_assert.svh"

// Usage:
// The input channel (s_valid/s_ready) takes one frame description per transfer:
// a time in seconds, a play mode and an elapsed/total pair for the progress bar.
// The result channel (m_valid/m_ready) returns eight row words per frame, row 0
// first, with m_last_row set on row 7.
// An input transfer passes through the prep stage (digit split and a
// one-bit-per-cycle bar division), then the drawer writes one row per cycle into
// a two-bank frame RAM, and the reader streams a complete bank out through a
// two-entry output buffer. The prep stage takes a new frame only as it hands the
// last one to the drawer; the single write port of the frame RAM takes one row a
// cycle, and its read port matches that rate while the receiver keeps up.
// When the receiver stalls, the output buffer fills, reads stop, the drawer
// stops once both banks are full, and s_ready drops; nothing is lost.
// Synchronous active-low reset empties all stages; the RAM needs no clearing.
module elapsed_time_matrix_renderer_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [etmr_pkg::TIME_W-1:0] s_time_seconds,
    input  logic [etmr_pkg::MODE_W-1:0] s_play_mode,
    input  logic [etmr_pkg::SEC_W-1:0]  s_elapsed_seconds,
    input  logic [etmr_pkg::SEC_W-1:0]  s_total_seconds,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [etmr_pkg::ROW_W-1:0]  m_row_index,
    output logic [etmr_pkg::PIX_W-1:0]  m_row_pixels,
    output logic                        m_last_row
);

    // Overwrite one 8-wide cell; only glyph columns inside the frame land.
    function automatic logic [31:0] put_cell(input logic [31:0] acc,
                                             input logic [7:0] bits,
                                             input logic [4:0] x0,
                                             input logic en);
        logic [7:0]  rev;
        logic [39:0] span;
        logic [39:0] ink;
        for (int c = 0; c < 8; c++) begin
            rev[c] = bits[7 - c];
        end
        span = 40'hFF << x0;
        ink  = {32'b0, rev} << x0;
        return en ? ((acc & ~span[31:0]) | ink[31:0]) : acc;
    endfunction

    // Build one row of the frame from its description.
    function automatic logic [31:0] build_row(input etmr_pkg::frame_params_t p,
                                              input logic [etmr_pkg::ROW_W-1:0] r);
        logic [31:0] acc;
        logic [3:0]  icon;
        acc = '0;
        case (p.mode)
            etmr_pkg::MODE_PLAY:  icon = etmr_pkg::GLYPH_PLAY;
            etmr_pkg::MODE_PAUSE: icon = etmr_pkg::GLYPH_PAUSE;
            default:              icon = etmr_pkg::GLYPH_STOP;
        endcase
        if (r < etmr_pkg::BLANK_ROW) begin
            acc = put_cell(acc, etmr_pkg::glyph_row(icon, r), etmr_pkg::X_ICON,
                           p.mode != etmr_pkg::MODE_NONE);
            acc = put_cell(acc, etmr_pkg::glyph_row(p.hours, r), etmr_pkg::X_HOURS,
                           p.hour_mode);
            acc = put_cell(acc, etmr_pkg::glyph_row(etmr_pkg::GLYPH_COLON, r),
                           etmr_pkg::X_COLON_H, p.hour_mode);
            acc = put_cell(acc, etmr_pkg::glyph_row(p.min_tens, r), etmr_pkg::X_MIN_TENS,
                           p.hour_mode || (p.min_tens != 4'd0));
            acc = put_cell(acc, etmr_pkg::glyph_row(p.min_units, r),
                           etmr_pkg::X_MIN_UNITS, 1'b1);
            acc = put_cell(acc, etmr_pkg::glyph_row(etmr_pkg::GLYPH_COLON, r),
                           etmr_pkg::X_COLON_M, 1'b1);
            acc = put_cell(acc, etmr_pkg::glyph_row(p.sec_tens, r), etmr_pkg::X_SEC_TENS,
                           1'b1);
            acc = put_cell(acc, etmr_pkg::glyph_row(p.sec_units, r),
                           etmr_pkg::X_SEC_UNITS, 1'b1);
        end else if (r == etmr_pkg::BAR_ROW_ODD) begin
            for (int i = 0; i < 32; i++) begin
                acc[i] = !p.bar_dark && (6'(2 * i + 1) <= p.bar_level);
            end
        end else if (r == etmr_pkg::LAST_ROW) begin
            for (int i = 0; i < 32; i++) begin
                acc[i] = !p.bar_dark && (6'(2 * i) <= p.bar_level);
            end
        end
        return acc;
    endfunction

    // Prep stage output.
    logic                    p_valid;
    logic                    p_ready;
    etmr_pkg::frame_params_t p_params;

    // Drawer state.
    logic                           d_busy_reg;
    logic [etmr_pkg::ROW_W-1:0]     d_row_reg;
    logic                           wbank_reg;
    etmr_pkg::frame_params_t        d_par_reg;
    logic                           d_finish;
    logic                           next_bank;
    logic                           bank_free;
    logic [etmr_pkg::PIX_W-1:0]     draw_pixels;

    // Bank state shared by drawer and reader.
    logic [1:0]                     full_reg;
    logic [1:0]                     full_next;

    // Reader and output buffer state.
    logic                           rbank_reg;
    logic [etmr_pkg::ROW_W-1:0]     r_row_reg;
    logic                           pend_reg;
    logic [etmr_pkg::ROW_W-1:0]     pend_row_reg;
    logic [1:0]                     cnt_reg;
    logic                           wptr_reg;
    logic                           rptr_reg;
    logic [etmr_pkg::ROW_W-1:0]     f_row_reg [2];
    logic [etmr_pkg::PIX_W-1:0]     f_pix_reg [2];
    logic [etmr_pkg::PIX_W-1:0]     rd_data;
    logic                           fifo_pop;
    logic [1:0]                     fill_after;
    logic                           rd_issue;
    logic                           rd_release;

    etmr_prep u_prep (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_seconds    (s_time_seconds),
        .s_play_mode       (s_play_mode),
        .s_elapsed_seconds (s_elapsed_seconds),
        .s_total_seconds   (s_total_seconds),
        .p_valid           (p_valid),
        .p_ready           (p_ready),
        .p_params          (p_params)
    );

    // The drawer takes a new frame when idle or on its last row, into a free bank.
    // A bank whose last row is being read this cycle counts as free.
    assign d_finish  = d_busy_reg && (d_row_reg == etmr_pkg::LAST_ROW);
    assign next_bank = d_finish ? ~wbank_reg : wbank_reg;
    assign bank_free = !full_reg[next_bank] || (rd_release && (rbank_reg == next_bank));
    assign p_ready   = (!d_busy_reg || d_finish) && bank_free;

    assign draw_pixels = build_row(d_par_reg, d_row_reg);

    // Drawer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_busy_reg <= 1'b0;
            d_row_reg  <= '0;
            wbank_reg  <= 1'b0;
        end else begin
            if (d_finish) begin
                wbank_reg <= ~wbank_reg;
            end
            if (p_valid && p_ready) begin
                d_busy_reg <= 1'b1;
                d_row_reg  <= '0;
            end else if (d_finish) begin
                d_busy_reg <= 1'b0;
            end else if (d_busy_reg) begin
                d_row_reg <= d_row_reg + 3'd1;
            end
        end
    end

    // Latched frame description for the drawer.
    always_ff @(posedge aclk) begin
        if (p_valid && p_ready) begin
            d_par_reg <= p_params;
        end
    end

    // Frame RAM: drawer writes rows, reader reads finished banks.
    etmr_ram #(
        .WIDTH (etmr_pkg::PIX_W),
        .DEPTH (etmr_pkg::RAM_DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (d_busy_reg),
        .wr_addr ({wbank_reg, d_row_reg}),
        .wr_data (draw_pixels),
        .rd_en   (rd_issue),
        .rd_addr ({rbank_reg, r_row_reg}),
        .rd_data (rd_data)
    );

    // Read only when the output buffer can take the returning row.
    assign fifo_pop   = m_valid && m_ready;
    assign fill_after = cnt_reg + {1'b0, pend_reg} - {1'b0, fifo_pop};
    assign rd_issue   = full_reg[rbank_reg] && (fill_after < 2'd2);
    assign rd_release = rd_issue && (r_row_reg == etmr_pkg::LAST_ROW);

    // A finished bank becomes full; a bank whose last row is read becomes free.
    always_comb begin
        full_next = full_reg;
        if (d_finish) begin
            full_next[wbank_reg] = 1'b1;
        end
        if (rd_release) begin
            full_next[rbank_reg] = 1'b0;
        end
    end

    // Bank flags and reader control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg  <= '0;
            rbank_reg <= 1'b0;
            r_row_reg <= '0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end else begin
            full_reg <= full_next;
            if (rd_release) begin
                rbank_reg <= ~rbank_reg;
            end
            if (rd_issue) begin
                r_row_reg <= r_row_reg + 3'd1;
            end
            pend_reg <= rd_issue;
            cnt_reg  <= cnt_reg + {1'b0, pend_reg} - {1'b0, fifo_pop};
            if (pend_reg) begin
                wptr_reg <= ~wptr_reg;
            end
            if (fifo_pop) begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    // Output buffer payload.
    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            pend_row_reg <= r_row_reg;
        end
        if (pend_reg) begin
            f_row_reg[wptr_reg] <= pend_row_reg;
            f_pix_reg[wptr_reg] <= rd_data;
        end
    end

    // Result channel.
    assign m_valid      = (cnt_reg != 2'd0);
    assign m_row_index  = f_row_reg[rptr_reg];
    assign m_row_pixels = f_pix_reg[rptr_reg];
    assign m_last_row   = (f_row_reg[rptr_reg] == etmr_pkg::LAST_ROW);

    // The drawer never writes into a bank that still waits to be read.
    `ETMR_ASSERT_HOLDS(a_draw_bank_free, d_busy_reg, !full_reg[wbank_reg])
    // A returning row always finds room in the output buffer.
    `ETMR_ASSERT_HOLDS(a_buffer_room, pend_reg && !fifo_pop, cnt_reg != 2'd2)
    // Reading the last row of a bank hands that bank back to the drawer.
    `ETMR_ASSERT_NEXT(a_bank_released, rd_release, !full_reg[~rbank_reg])
    // Finishing a bank and releasing a bank never hit the same bank.
    `ETMR_ASSERT_HOLDS(a_bank_disjoint, d_finish && rd_release, wbank_reg != rbank_reg)

endmodule

// ===== hdl/etmr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module etmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== hdl/etmr_prep.sv =====
// Input stage: splits the time into digits and divides out the progress bar level.
`timescale 1ns / 1ps

module etmr_prep (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [etmr_pkg::TIME_W-1:0]     s_time_seconds,
    input  logic [etmr_pkg::MODE_W-1:0]     s_play_mode,
    input  logic [etmr_pkg::SEC_W-1:0]      s_elapsed_seconds,
    input  logic [etmr_pkg::SEC_W-1:0]      s_total_seconds,
    output logic                            p_valid,
    input  logic                            p_ready,
    output etmr_pkg::frame_params_t         p_params
);

    // Work phases after the input transfer.
    localparam logic [2:0] PH_SPLIT  = 3'd0;
    localparam logic [2:0] PH_SUB    = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_LAST   = 3'd6;

    logic busy_reg;
    logic done_reg;
    logic [2:0] phase_reg;

    logic [etmr_pkg::TIME_W-1:0] time_reg;
    logic [etmr_pkg::MODE_W-1:0] mode_reg;
    logic                        dark_reg;
    logic [etmr_pkg::BAR_W-1:0]  rem_reg;
    logic [etmr_pkg::BAR_W-2:0]  div_reg;
    logic                        full_reg;
    logic [5:0]                  quot_reg;
    logic [3:0]                  hours_reg;
    logic [9:0]                  tmin_reg;
    logic [5:0]                  mins_reg;
    logic [5:0]                  secs_reg;
    logic [3:0]                  min_tens_reg;
    logic [3:0]                  min_units_reg;
    logic [3:0]                  sec_tens_reg;
    logic [3:0]                  sec_units_reg;

    logic                        accept;
    logic [etmr_pkg::TIME_W-1:0] time_sat;
    logic [etmr_pkg::BAR_W-1:0]  elapsed_x63;
    logic [3:0]                  hours_calc;
    logic [32:0]                 min_prod;
    logic [9:0]                  tmin_calc;
    logic [5:0]                  mins_calc;
    logic [5:0]                  secs_calc;
    logic [3:0]                  min_tens_calc;
    logic [3:0]                  sec_tens_calc;
    logic [3:0]                  min_units_calc;
    logic [3:0]                  sec_units_calc;
    logic                        div_ge;

    assign accept  = s_valid && s_ready;
    assign s_ready = !busy_reg || (done_reg && p_ready);
    assign p_valid = done_reg;

    // Saturate the time and form 63 * elapsed as a shift and subtract.
    assign time_sat = (s_time_seconds > etmr_pkg::TIME_LIMIT) ? etmr_pkg::TIME_LIMIT
                                                               : s_time_seconds;
    assign elapsed_x63 = {s_elapsed_seconds, 6'b0} - {6'b0, s_elapsed_seconds};

    // Hours by comparing against each whole hour.
    always_comb begin
        hours_calc = '0;
        for (int h = 1; h <= etmr_pkg::MAX_HOURS; h++) begin
            if (time_reg >= etmr_pkg::TIME_W'(h * etmr_pkg::SECS_PER_HOUR)) begin
                hours_calc = hours_calc + 4'd1;
            end
        end
    end

    // Total minutes by a reciprocal multiply; exact for times up to the limit.
    assign min_prod  = {17'b0, time_reg} * {16'b0, etmr_pkg::MIN_RECIP};
    assign tmin_calc = min_prod[etmr_pkg::MIN_SHIFT +: 10];

    // Minutes within the hour and seconds within the minute.
    assign mins_calc = 6'(tmin_reg - 10'(hours_reg) * 10'd60);
    assign secs_calc = 6'(time_reg - 16'(tmin_reg) * 16'(etmr_pkg::SECS_PER_MIN));

    // Tens digits by comparison, units by subtraction.
    always_comb begin
        min_tens_calc = '0;
        sec_tens_calc = '0;
        for (int k = 1; k <= 5; k++) begin
            if (mins_reg >= 6'(10 * k)) begin
                min_tens_calc = min_tens_calc + 4'd1;
            end
            if (secs_reg >= 6'(10 * k)) begin
                sec_tens_calc = sec_tens_calc + 4'd1;
            end
        end
        min_units_calc = 4'(mins_reg - 6'(min_tens_calc) * 6'd10);
        sec_units_calc = 4'(secs_reg - 6'(sec_tens_calc) * 6'd10);
    end

    // One restoring division step in each phase after the split.
    assign div_ge = rem_reg >= {1'b0, div_reg};

    // Phase sequencing and handshake state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_SPLIT;
        end else if (accept) begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            phase_reg <= PH_SPLIT;
        end else if (p_valid && p_ready) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (busy_reg && !done_reg) begin
            phase_reg <= phase_reg + 3'd1;
            if (phase_reg == PH_LAST) begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            time_reg <= time_sat;
            mode_reg <= s_play_mode;
            dark_reg <= (s_total_seconds == '0);
            rem_reg  <= elapsed_x63;
            div_reg  <= {s_total_seconds, 5'b0};
            quot_reg <= '0;
        end else if (busy_reg && !done_reg) begin
            case (phase_reg)
                PH_SPLIT: begin
                    hours_reg <= hours_calc;
                    tmin_reg  <= tmin_calc;
                    full_reg  <= rem_reg >= {div_reg, 1'b0};
                end
                PH_SUB: begin
                    mins_reg <= mins_calc;
                    secs_reg <= secs_calc;
                end
                PH_DIGITS: begin
                    min_tens_reg  <= min_tens_calc;
                    min_units_reg <= min_units_calc;
                    sec_tens_reg  <= sec_tens_calc;
                    sec_units_reg <= sec_units_calc;
                end
                default: begin
                end
            endcase
            // Six quotient bits, most significant first.
            if (phase_reg != PH_SPLIT) begin
                if (div_ge) begin
                    rem_reg <= rem_reg - {1'b0, div_reg};
                end
                quot_reg <= {quot_reg[4:0], div_ge};
                div_reg  <= div_reg >> 1;
            end
        end
    end

    // Frame description handed to the row drawer.
    always_comb begin
        p_params.mode      = mode_reg;
        p_params.hour_mode = time_reg >= etmr_pkg::TIME_W'(etmr_pkg::SECS_PER_HOUR);
        p_params.hours     = hours_reg;
        p_params.min_tens  = min_tens_reg;
        p_params.min_units = min_units_reg;
        p_params.sec_tens  = sec_tens_reg;
        p_params.sec_units = sec_units_reg;
        p_params.bar_dark  = dark_reg;
        p_params.bar_level = full_reg ? 6'h3F : quot_reg;
    end

endmodule

// ===== test/elapsed_time_matrix_renderer_core_checker.sv =====
// Row checker: predicts each rendered frame and compares the streamed rows against it.
`timescale 1ns / 1ps

module elapsed_time_matrix_renderer_core_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [etmr_pkg::TIME_W-1:0] s_time_seconds,
    input  logic [etmr_pkg::MODE_W-1:0] s_play_mode,
    input  logic [etmr_pkg::SEC_W-1:0]  s_elapsed_seconds,
    input  logic [etmr_pkg::SEC_W-1:0]  s_total_seconds,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [etmr_pkg::ROW_W-1:0]  m_row_index,
    input  logic [etmr_pkg::PIX_W-1:0]  m_row_pixels,
    input  logic                        m_last_row,
    output int                          fail_count,
    output int                          rows_outstanding,
    output int                          frames_rendered,
    output int                          rows_checked
);

    typedef logic [7:0][31:0] frame_t;

    typedef struct packed {
        logic [etmr_pkg::ROW_W-1:0] row_index;
        logic [etmr_pkg::PIX_W-1:0] row_pixels;
        logic                       last_row;
    } row_word_t;

    // 3x5 font bitmaps, five row bytes per glyph with the top row leftmost.
    localparam logic [0:13][39:0] GLYPH_BITMAPS = {
        40'h2050505020, 40'h2060202070, 40'h6010204070, 40'h6010601060,
        40'h5050701010, 40'h7040601060, 40'h2040605020, 40'h7010202020,
        40'h2050205020, 40'h2050301020, 40'h0040004000, 40'h4060706040,
        40'h5050505050, 40'h0070707000
    };

    row_word_t expected_rows[$];

    // Stamp one 8x8 cell at column x0; pixels past column 31 are clipped.
    function automatic frame_t place_glyph(input frame_t f, input logic [3:0] glyph,
                                           input logic [4:0] x0);
        logic [7:0] bits;
        int col;
        for (int r = 0; r < 8; r++) begin
            bits = (r < 5) ? GLYPH_BITMAPS[glyph][39 - 8 * r -: 8] : 8'h00;
            for (int c = 0; c < 8; c++) begin
                col = int'(x0) + c;
                if (col < etmr_pkg::PIX_W)
                    f[r][col] = bits[7 - c];
            end
        end
        return f;
    endfunction

    // Build the whole frame for one input transfer.
    function automatic frame_t render_frame(input logic [etmr_pkg::TIME_W-1:0] t_in,
                                            input logic [etmr_pkg::MODE_W-1:0] mode,
                                            input logic [etmr_pkg::SEC_W-1:0]  elapsed,
                                            input logic [etmr_pkg::SEC_W-1:0]  total);
        frame_t      f;
        int          t, hrs, mins, secs;
        logic [3:0]  hour_digit, min_tens, min_units, sec_tens, sec_units;
        logic [63:0] lhs;
        logic [63:0] total_wide;
        t = int'(t_in);
        if (t > int'(etmr_pkg::TIME_LIMIT))
            t = int'(etmr_pkg::TIME_LIMIT);
        hrs        = t / etmr_pkg::SECS_PER_HOUR;
        mins       = t / etmr_pkg::SECS_PER_MIN - hrs * 60;
        secs       = t % etmr_pkg::SECS_PER_MIN;
        hour_digit = 4'(hrs);
        min_tens   = 4'(mins / 10);
        min_units  = 4'(mins % 10);
        sec_tens   = 4'(secs / 10);
        sec_units  = 4'(secs % 10);

        f = '0;
        case (mode)
            etmr_pkg::MODE_PLAY:  f = place_glyph(f, etmr_pkg::GLYPH_PLAY, etmr_pkg::X_ICON);
            etmr_pkg::MODE_PAUSE: f = place_glyph(f, etmr_pkg::GLYPH_PAUSE, etmr_pkg::X_ICON);
            etmr_pkg::MODE_STOP:  f = place_glyph(f, etmr_pkg::GLYPH_STOP, etmr_pkg::X_ICON);
            default: ;
        endcase

        // Short form hides a leading zero minute; hour form shows H: and both minutes.
        if (t < etmr_pkg::SECS_PER_HOUR) begin
            if (min_tens != 0)
                f = place_glyph(f, min_tens, etmr_pkg::X_MIN_TENS);
        end else begin
            f = place_glyph(f, hour_digit, etmr_pkg::X_HOURS);
            f = place_glyph(f, etmr_pkg::GLYPH_COLON, etmr_pkg::X_COLON_H);
            f = place_glyph(f, min_tens, etmr_pkg::X_MIN_TENS);
        end
        f = place_glyph(f, min_units, etmr_pkg::X_MIN_UNITS);
        f = place_glyph(f, etmr_pkg::GLYPH_COLON, etmr_pkg::X_COLON_M);
        f = place_glyph(f, sec_tens, etmr_pkg::X_SEC_TENS);
        f = place_glyph(f, sec_units, etmr_pkg::X_SEC_UNITS);

        // Progress bar: exact cross-multiply, half steps on the upper bar row.
        f[etmr_pkg::BAR_ROW_ODD] = '0;
        f[etmr_pkg::LAST_ROW]    = '0;
        if (total != 0) begin
            lhs        = {44'd0, elapsed} * 64'd63;
            total_wide = {44'd0, total};
            for (int i = 0; i < etmr_pkg::PIX_W; i++) begin
                if ((64'(2 * i)) * total_wide <= lhs)
                    f[etmr_pkg::LAST_ROW][i] = 1'b1;
                if ((64'(2 * i + 1)) * total_wide <= lhs)
                    f[etmr_pkg::BAR_ROW_ODD][i] = 1'b1;
            end
        end
        return f;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] MISMATCH %0s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        fail_count++;
    endtask

    // Queue eight expected rows per input transfer; check each result transfer.
    always @(posedge aclk) begin : watch
        frame_t    f;
        row_word_t w;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                f = render_frame(s_time_seconds, s_play_mode, s_elapsed_seconds,
                                 s_total_seconds);
                for (int k = 0; k < 8; k++) begin
                    w.row_index  = etmr_pkg::ROW_W'(k);
                    w.row_pixels = f[k];
                    w.last_row   = (k == int'(etmr_pkg::LAST_ROW));
                    expected_rows.push_back(w);
                end
                rows_outstanding = rows_outstanding + 8;
                frames_rendered  = frames_rendered + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("row with no frame pending", 32'd0, m_row_pixels);
                end else begin
                    w = expected_rows.pop_front();
                    rows_outstanding = rows_outstanding - 1;
                    rows_checked     = rows_checked + 1;
                    if (m_row_index !== w.row_index)
                        report_mismatch("row_index", 32'(w.row_index), 32'(m_row_index));
                    if (m_row_pixels !== w.row_pixels)
                        report_mismatch($sformatf("row_pixels of row %0d", w.row_index),
                                        w.row_pixels, m_row_pixels);
                    if (m_last_row !== w.last_row)
                        report_mismatch($sformatf("last_row of row %0d", w.row_index),
                                        32'(w.last_row), 32'(m_last_row));
                end
            end
        end
    end

endmodule

// ===== test/tb_elapsed_time_matrix_renderer_core.sv =====
// Testbench top: clock, reset, frame stimulus, receiver stalls and the final verdict.
`timescale 1ns / 1ps

module tb_elapsed_time_matrix_renderer_core;

    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_FRAMES  = 440;
    localparam int FINAL_STRETCH  = 60;

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [etmr_pkg::TIME_W-1:0] s_time_seconds    = '0;
    logic [etmr_pkg::MODE_W-1:0] s_play_mode       = etmr_pkg::MODE_NONE;
    logic [etmr_pkg::SEC_W-1:0]  s_elapsed_seconds = '0;
    logic [etmr_pkg::SEC_W-1:0]  s_total_seconds   = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [etmr_pkg::ROW_W-1:0]  m_row_index;
    logic [etmr_pkg::PIX_W-1:0]  m_row_pixels;
    logic                        m_last_row;

    int fail_count;
    int rows_outstanding;
    int frames_rendered;
    int rows_checked;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;

    elapsed_time_matrix_renderer_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_seconds    (s_time_seconds),
        .s_play_mode       (s_play_mode),
        .s_elapsed_seconds (s_elapsed_seconds),
        .s_total_seconds   (s_total_seconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_row_index       (m_row_index),
        .m_row_pixels      (m_row_pixels),
        .m_last_row        (m_last_row)
    );

    elapsed_time_matrix_renderer_core_checker u_row_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_seconds    (s_time_seconds),
        .s_play_mode       (s_play_mode),
        .s_elapsed_seconds (s_elapsed_seconds),
        .s_total_seconds   (s_total_seconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_row_index       (m_row_index),
        .m_row_pixels      (m_row_pixels),
        .m_last_row        (m_last_row),
        .fail_count        (fail_count),
        .rows_outstanding  (rows_outstanding),
        .frames_rendered   (frames_rendered),
        .rows_checked      (rows_checked)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: random stall bursts of random length while enabled.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (receiver_stalls && $urandom_range(0, 6) == 0) begin
            m_ready    = 1'b0;
            stall_left = int'($urandom_range(1, 5)) - 1;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one frame at the falling edge and hold it until the transfer happens.
    task automatic send_frame(input logic [etmr_pkg::TIME_W-1:0] t,
                              input logic [etmr_pkg::MODE_W-1:0] mode,
                              input logic [etmr_pkg::SEC_W-1:0] elapsed,
                              input logic [etmr_pkg::SEC_W-1:0] total);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_time_seconds    = t;
        s_play_mode       = mode;
        s_elapsed_seconds = elapsed;
        s_total_seconds   = total;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Random frame: mostly realistic times and bar ratios, some raw noise.
    task automatic send_random_frame();
        logic [etmr_pkg::TIME_W-1:0] t;
        logic [etmr_pkg::MODE_W-1:0] mode;
        logic [etmr_pkg::SEC_W-1:0]  elapsed, total;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            t = etmr_pkg::TIME_W'($urandom_range(0, 3599));
        else if (pick < 7)
            t = etmr_pkg::TIME_W'($urandom_range(3600, 35999));
        else if (pick == 7)
            t = etmr_pkg::TIME_W'($urandom_range(36000, 65535));
        else
            t = etmr_pkg::TIME_W'($urandom);
        mode = etmr_pkg::MODE_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            total   = '0;
            elapsed = etmr_pkg::SEC_W'($urandom);
        end else if (pick < 5) begin
            total   = etmr_pkg::SEC_W'($urandom_range(1, 300));
            elapsed = etmr_pkg::SEC_W'($urandom_range(0, 32'(total) + 32'(total) / 8));
        end else if (pick < 8) begin
            total   = etmr_pkg::SEC_W'($urandom);
            elapsed = etmr_pkg::SEC_W'($urandom_range(0, 32'(total)));
        end else begin
            total   = etmr_pkg::SEC_W'($urandom);
            elapsed = etmr_pkg::SEC_W'($urandom);
        end
        send_frame(t, mode, elapsed, total);
    endtask

    // Stop offering frames until every expected row has come back.
    task automatic drain_rows();
        s_valid = 1'b0;
        while (rows_outstanding != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed frames: display forms, icons, time limits and bar corners.
        send_frame(16'd0,     etmr_pkg::MODE_NONE,  20'd0,       20'd0);
        send_frame(16'd59,    etmr_pkg::MODE_PLAY,  20'd0,       20'd1);
        send_frame(16'd60,    etmr_pkg::MODE_PAUSE, 20'd1,       20'd1);
        send_frame(16'd599,   etmr_pkg::MODE_STOP,  20'd1,       20'd2);
        send_frame(16'd600,   etmr_pkg::MODE_PLAY,  20'd31,      20'd63);
        send_frame(16'd3599,  etmr_pkg::MODE_PAUSE, 20'd50,      20'd100);
        send_frame(16'd3600,  etmr_pkg::MODE_STOP,  20'hFFFFF,   20'hFFFFF);
        send_frame(16'd35999, etmr_pkg::MODE_PLAY,  20'hFFFFF,   20'd1);
        send_frame(16'd36000, etmr_pkg::MODE_PAUSE, 20'd1000,    20'd10);
        send_frame(16'hFFFF,  etmr_pkg::MODE_STOP,  20'd0,       20'hFFFFF);
        send_frame(16'hFFFF,  etmr_pkg::MODE_NONE,  20'hFFFFF,   20'd0);
        send_frame(16'd7199,  etmr_pkg::MODE_NONE,  20'd1,       20'd63);
        send_frame(16'd10000, etmr_pkg::MODE_PLAY,  20'd63,      20'd126);
        send_frame(16'd1234,  etmr_pkg::MODE_STOP,  20'd62,      20'd63);
        send_frame(16'hAAAA,  etmr_pkg::MODE_PAUSE, 20'hAAAAA,   20'h55555);
        send_frame(16'h5555,  etmr_pkg::MODE_PLAY,  20'h55555,   20'hAAAAA);
        send_frame(16'd3661,  etmr_pkg::MODE_NONE,  20'd2,       20'd126);
        send_frame(16'd9,     etmr_pkg::MODE_STOP,  20'hFFFFE,   20'hFFFFF);
        drain_rows();

        // Random frames with idling on both sides, a full drain in the middle.
        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            if (n == RANDOM_FRAMES / 2) begin
                drain_rows();
                sender_gaps = 1'b0;
            end
            if (n == 3 * RANDOM_FRAMES / 4) begin
                sender_gaps     = 1'b1;
                receiver_stalls = 1'b0;
            end
            if (n == RANDOM_FRAMES - FINAL_STRETCH) begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            send_random_frame();
        end
        s_valid = 1'b0;

        while (rows_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d frames rendered, %0d row words checked, %0d mismatches.",
                 frames_rendered, rows_checked, fail_count);
        $display("Covered short and hour time forms, saturation, all icons and bar corners.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
